// File: rtl/core/assert_macros.svh
// Assertion helpers for the RTL files, used by dbs_match.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: rtl/core/dbs_pkg.sv
`default_nettype none

package dbs_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int BASE_BITS   = 2;
    localparam int WINDOW_W    = MAX_PATTERN * BASE_BITS;
    localparam int SHIFT_W     = $clog2(WINDOW_W) + 1;
    localparam int LEN_W       = 6;
    localparam int RUN_W       = 6;
    localparam int POS_W       = 32;
    localparam int SEQ_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BASES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1
    } cfg_reg_e;

    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
    localparam logic [BYTE_W-1:0] LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    typedef logic [BASE_BITS-1:0] base_code_t;
    localparam base_code_t CODE_A = 2'd0;
    localparam base_code_t CODE_C = 2'd1;
    localparam base_code_t CODE_G = 2'd2;
    localparam base_code_t CODE_T = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] base_byte;
        logic              sequence_start;
        logic [SEQ_W-1:0]  sequence_id;
    } base_item_t;

    typedef struct packed {
        logic [POS_W-1:0] match_start;
        logic             on_reverse;
        logic [SEQ_W-1:0] match_sequence;
        logic             last_of_run;
    } hit_item_t;

    // Pattern as seen by the comparators, derived from the configuration.
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [WINDOW_W-1:0] mask;
        logic [WINDOW_W-1:0] fwd_target;
        logic [WINDOW_W-1:0] rev_target;
    } pattern_t;

    // Scan state after the most recent request, plus its pass-through fields.
    typedef struct packed {
        logic                valid;
        logic                is_base;
        logic [SEQ_W-1:0]    seq;
        logic [WINDOW_W-1:0] window;
        logic [RUN_W-1:0]    run;
        logic [POS_W-1:0]    pos;
    } front_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b inside {[LOWER_A:LOWER_Z]})
        begin
            r = b - CASE_DELTA;
        end
        return r;
    endfunction

    // Reverses the order of the 2-bit bases in a full window word.
    function automatic logic [WINDOW_W-1:0] reverse_bases(input logic [WINDOW_W-1:0] w);
        logic [WINDOW_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            r[i*BASE_BITS +: BASE_BITS] = w[(MAX_PATTERN-1-i)*BASE_BITS +: BASE_BITS];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dbs_cfg.sv
`default_nettype none

module dbs_cfg
    import dbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output pattern_t                    pattern
);

    logic [WINDOW_W-1:0] pattern_bases_reg;
    logic [LEN_W-1:0]    pattern_length_reg;
    pattern_t            pattern_reg;
    pattern_t            pattern_next;

    logic [LEN_W-1:0]   eff_len;
    logic [SHIFT_W-1:0] drop_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bases_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_PATTERN_BASES:  pattern_bases_reg  <= cfg_data[WINDOW_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The window keeps the newest base in the low bits, so the forward target is
    // the pattern with its base order reversed, while the reverse complement
    // target is simply the pattern with every base inverted.
    always_comb
    begin
        eff_len = pattern_length_reg;
        if (pattern_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN))
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        drop_bits = SHIFT_W'(WINDOW_W) - SHIFT_W'({eff_len, 1'b0});

        pattern_next.len        = eff_len;
        pattern_next.mask       = {WINDOW_W{1'b1}} >> drop_bits;
        pattern_next.fwd_target = reverse_bases(pattern_bases_reg) >> drop_bits;
        pattern_next.rev_target = ~pattern_bases_reg & pattern_next.mask;
    end

    // The reset value is the one-base pattern A.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg.len        <= LEN_W'(1);
            pattern_reg.mask       <= WINDOW_W'({BASE_BITS{1'b1}});
            pattern_reg.fwd_target <= '0;
            pattern_reg.rev_target <= WINDOW_W'({BASE_BITS{1'b1}});
        end
        else
        begin
            pattern_reg <= pattern_next;
        end
    end

    assign pattern = pattern_reg;

endmodule

`default_nettype wire

// File: rtl/core/dbs_front.sv
`default_nettype none

module dbs_front
    import dbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       base_valid,
    output logic            base_ready,
    input  wire base_item_t base_item,
    input  wire logic       advance,
    output front_t          front
);

    front_t     front_reg;
    front_t     front_next;
    logic       accept;
    logic [BYTE_W-1:0] folded;
    base_code_t code;
    logic       code_ok;

    assign base_ready = !front_reg.valid || advance;
    assign accept     = base_valid && base_ready;
    assign folded     = fold_case(base_item.base_byte);

    always_comb
    begin
        code    = CODE_A;
        code_ok = 1'b1;
        case (folded)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        front_next = front_reg;
        if (advance)
        begin
            front_next.valid = 1'b0;
        end
        if (accept)
        begin
            front_next.valid   = 1'b1;
            front_next.is_base = code_ok;
            front_next.seq     = base_item.sequence_id;
            if (base_item.sequence_start)
            begin
                front_next.pos = POS_W'(1);
                front_next.run = '0;
            end
            else if (front_reg.pos != POS_MAX)
            begin
                front_next.pos = front_reg.pos + POS_W'(1);
            end
            if (!code_ok)
            begin
                front_next.run = '0;
            end
            else
            begin
                front_next.window = {front_reg.window[WINDOW_W-BASE_BITS-1:0], code};
                if (front_next.run != RUN_MAX)
                begin
                    front_next.run = front_next.run + RUN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// File: rtl/core/dbs_match.sv
`default_nettype none
`include "assert_macros.svh"

module dbs_match
    import dbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire front_t   front,
    input  wire pattern_t pattern,
    output logic          advance,
    output logic          hit_valid,
    input  wire logic     hit_ready,
    output hit_item_t     hit_item
);

    logic             pend_fwd_reg;
    logic             pend_fwd_next;
    logic             pend_rev_reg;
    logic             pend_rev_next;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] start_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;

    logic [WINDOW_W-1:0] win;
    logic run_ok;
    logic fwd_hit;
    logic rev_hit;
    logic any_hit;
    logic last;
    logic take;
    logic slot_free;

    assign win     = front.window & pattern.mask;
    assign run_ok  = front.valid && front.is_base && (front.run >= pattern.len);
    assign fwd_hit = run_ok && (win == pattern.fwd_target);
    assign rev_hit = run_ok && (win == pattern.rev_target);
    assign any_hit = fwd_hit || rev_hit;

    // The forward hit is shown first; the slot is free once its last hit leaves.
    assign hit_valid = pend_fwd_reg || pend_rev_reg;
    assign last      = !(pend_fwd_reg && pend_rev_reg);
    assign take      = hit_valid && hit_ready;
    assign slot_free = !hit_valid || (take && last);
    assign advance   = front.valid && (slot_free || !any_hit);

    always_comb
    begin
        pend_fwd_next = pend_fwd_reg;
        pend_rev_next = pend_rev_reg;
        start_next    = start_reg;
        seq_next      = seq_reg;
        if (take)
        begin
            if (pend_fwd_reg)
            begin
                pend_fwd_next = 1'b0;
            end
            else
            begin
                pend_rev_next = 1'b0;
            end
        end
        if (advance && any_hit)
        begin
            pend_fwd_next = fwd_hit;
            pend_rev_next = rev_hit;
            start_next    = front.pos - POS_W'(pattern.len) + POS_W'(1);
            seq_next      = front.seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_fwd_reg <= 1'b0;
            pend_rev_reg <= 1'b0;
        end
        else
        begin
            pend_fwd_reg <= pend_fwd_next;
            pend_rev_reg <= pend_rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        seq_reg   <= seq_next;
    end

    assign hit_item.match_start    = start_reg;
    assign hit_item.on_reverse     = !pend_fwd_reg;
    assign hit_item.match_sequence = seq_reg;
    assign hit_item.last_of_run    = last;

    `ASSERT_NEXT(a_second_hit_follows, clk, rst_n, take && !last, hit_valid && !pend_fwd_reg)
    `ASSERT_NEXT(a_hit_lands, clk, rst_n, advance && any_hit, hit_valid)
    `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(advance && any_hit && hit_valid && !(take && last)))

endmodule

`default_nettype wire

// File: rtl/core/dna_both_strand_exact_search.sv
// Both-strand exact pattern search over a stream of genome characters.
// The base channel (base_valid, base_ready, base_item) carries one character per
// request, with a start-of-sequence flag and a sequence id. The hit channel
// (hit_valid, hit_ready, hit_item) returns one request per match: the 1-based
// start of the matched window, the strand, the sequence id and a flag on the
// last hit caused by one character. Matches leave in position order, forward
// strand before reverse strand when both match at the same place.
// The user must write the pattern and its length through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce this.
// A write reaches the configuration registers and then the pattern register. The
// scan register holds each accepted character, whose hits are then offered from the
// hit register. The block takes one character every cycle while the single hit register
// has room; a character matching both strands holds it until both hits are taken, so
// a following matching character waits in the scan register with base_ready low.
// When the receiver stalls, characters that complete no match keep flowing; the
// first one that completes a match waits in the scan register, and base_ready
// stays low until the waiting hit is delivered.
// Reset clears the scan window, run count, position and all pending hits, and
// restores the pattern to one base, A.
`default_nettype none

module dna_both_strand_exact_search
    import dbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   base_valid,
    output logic                        base_ready,
    input  wire base_item_t             base_item,
    output logic                        hit_valid,
    input  wire logic                   hit_ready,
    output hit_item_t                   hit_item
);

    pattern_t pattern;
    front_t   front;
    logic     advance;

    // Configuration registers and the comparator targets derived from them.
    dbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern)
    );

    // Character decode and scan state: window, run of valid bases, position.
    dbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_valid (base_valid),
        .base_ready (base_ready),
        .base_item  (base_item),
        .advance    (advance),
        .front      (front)
    );

    // Window compare on both strands and the hit register that drives the port.
    dbs_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .front     (front),
        .pattern   (pattern),
        .advance   (advance),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .hit_item  (hit_item)
    );

endmodule

`default_nettype wire
